>>> src/sharpen_3x3_stream_defines.svh
// assertion macros for the 3x3 sharpen stream block
// used by files that need clk and rst in scope; depends on nothing else
`ifndef SHARPEN_3X3_STREAM_DEFINES_SVH
`define SHARPEN_3X3_STREAM_DEFINES_SVH

// condition must hold at every edge outside reset
`define SH3_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence must hold in the cycle after the trigger
`define SH3_CHECK_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

>>> src/sharp3_pkg.sv
// shared constants, register codes and result type of the 3x3 sharpen stream
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sharp3_pkg;

  localparam int MAX_WIDTH        = 2048;
  localparam int MAX_CHANNELS     = 4;
  localparam int MAX_HEIGHT       = 4096;
  localparam int AMOUNT_FRAC_BITS = 8;

  localparam int LINE_LEN    = MAX_WIDTH * MAX_CHANNELS;
  localparam int COL_W       = $clog2(LINE_LEN);
  localparam int ADDR_W      = COL_W + 1;
  localparam int STORE_DEPTH = 2 ** ADDR_W;
  localparam int WC_W        = $clog2(LINE_LEN + 1);
  localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
  localparam int CH_W        = $clog2(MAX_CHANNELS + 1);
  localparam int WIN_IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int MSR_IDX_W   = $clog2(2 * MAX_CHANNELS);

  localparam int SAMPLE_W     = 8;
  localparam int AMOUNT_W     = 12;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CHAN_REG_W   = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [AMOUNT_W-1:0]     AMOUNT_RESET   = AMOUNT_W'(256);
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET    = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET   = HEIGHT_REG_W'(480);
  localparam logic [CHAN_REG_W-1:0]   CHANNELS_RESET = CHAN_REG_W'(3);

  localparam logic [CFG_INDEX_W-1:0] REG_AMOUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                frame_end;
  } result_t;

endpackage

`default_nettype wire

>>> src/sharp3_ram.sv
// generic simple dual-read ram: one write port, two registered read ports
// read-first on a same-address write; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sharp3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> src/sharp3_out_queue.sv
// small result queue in flip-flops that decouples the pipeline from out_stall
// depends on sharp3_pkg and sharpen_3x3_stream_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "sharpen_3x3_stream_defines.svh"

module sharp3_out_queue (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  input  wire sharp3_pkg::result_t                push_item,
  input  wire logic                               stall,
  output logic                                    valid,
  output sharp3_pkg::result_t                     head,
  output logic [sharp3_pkg::QUEUE_CNT_W-1:0]      count
);

  sharp3_pkg::result_t                  slots [sharp3_pkg::QUEUE_DEPTH];
  logic [sharp3_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [sharp3_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic                                 pop;

  assign valid = (count != '0);
  assign head  = slots[rd_ptr];
  assign pop   = valid && !stall;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sharp3_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sharp3_pkg::QUEUE_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + sharp3_pkg::QUEUE_CNT_W'(1);
        2'b01:   count <= count - sharp3_pkg::QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `SH3_CHECK(a_queue_no_overflow, !push || pop || (count < sharp3_pkg::QUEUE_CNT_W'(sharp3_pkg::QUEUE_DEPTH)), "result queue overflow")
  `SH3_CHECK(a_queue_count_bound, count <= sharp3_pkg::QUEUE_CNT_W'(sharp3_pkg::QUEUE_DEPTH), "result queue count past depth")
  `SH3_CHECK_NEXT(a_queue_head_held, valid && stall, valid && (head == $past(head)), "stalled result changed")

endmodule

`default_nettype wire

>>> src/sharpen_3x3_stream.sv
// top level of the streaming 3x3 cross sharpen: counters, line store, pipeline
// depends on sharp3_pkg, sharp3_ram, sharp3_out_queue and the defines header
//
// usage:
//   input channel (in_valid / in_stall, operation, sample) takes one 8-bit
//   component per item in raster order, components of a pixel interleaved.
//   after the last component of a frame, send drain items (operation = 1)
//   until the result with frame_end appears: one row plus one pixel of them.
//   output channel (out_valid / out_stall, value, frame_end) gives one result
//   per component; frame_end marks the last component of the frame.
//   items that do not fit the frame phase (samples while draining, drains
//   before the frame is complete) are taken and give no result.
// pipeline: a result passes stages 1 to 3 and the result queue after the item
//   that completes its neighborhood, which comes width*channels + channels
//   items after the center component.
// throughput: one item per cycle while in_stall is low; each sample item does
//   one write and each item two reads of the line store ram, whose ports set that rate.
// reset: synchronous, restores register defaults (amount 1.0, 640x480, 3
//   components) and empties the pipeline and queue. line store is not cleared.
// stall: results collect in an 8-entry queue; in_stall rises only when the
//   queue plus items in flight could fill it, so a short out_stall does not
//   stop the input. writing a size register restarts the frame.
`timescale 1ns / 1ps
`default_nettype none
`include "sharpen_3x3_stream_defines.svh"

module sharpen_3x3_stream (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration write port
  input  wire logic                                 cfg_write,
  input  wire logic [sharp3_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [sharp3_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 operation,
  input  wire logic [sharp3_pkg::SAMPLE_W-1:0]      sample,
  // output channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [sharp3_pkg::SAMPLE_W-1:0]           value,
  output logic                                      frame_end
);

  localparam int SUM_W    = sharp3_pkg::WC_W + 1;
  localparam int CH2_W    = sharp3_pkg::CH_W + 1;
  localparam int SUM4_W   = sharp3_pkg::SAMPLE_W + 2;
  localparam int DIFF_W   = sharp3_pkg::SAMPLE_W + 3;
  localparam int PROD_W   = sharp3_pkg::AMOUNT_W + 1 + DIFF_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int CREDIT_W = sharp3_pkg::QUEUE_CNT_W + 1;
  localparam int SHIFT_W  = ACC_W - sharp3_pkg::AMOUNT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS =
    ACC_W'(1 << (sharp3_pkg::AMOUNT_FRAC_BITS - 1));

  // per-item flags carried from the counter stage to the window stage
  typedef struct packed {
    logic                            emit;
    logic                            last;
    logic                            up_ok;
    logic                            down_ok;
    logic                            left_ok;
    logic                            right_ok;
    logic [sharp3_pkg::SAMPLE_W-1:0] down;
  } stage1_t;

  // ---------------------------------------------------------------------------
  // configuration registers and effective sizes
  // ---------------------------------------------------------------------------
  logic [sharp3_pkg::AMOUNT_W-1:0]     amount_q;
  logic [sharp3_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [sharp3_pkg::HEIGHT_REG_W-1:0] image_height;
  logic [sharp3_pkg::CHAN_REG_W-1:0]   channels;
  logic                                restart;

  logic [sharp3_pkg::WIDTH_REG_W-1:0]  w_eff;
  logic [sharp3_pkg::ROW_W-1:0]        h_eff;
  logic [sharp3_pkg::CH_W-1:0]         ch_eff;
  logic [sharp3_pkg::WC_W-1:0]         wc;

  always_comb begin
    restart = 1'b0;
    if (cfg_write) begin
      case (cfg_index)
        sharp3_pkg::REG_WIDTH:    restart = 1'b1;
        sharp3_pkg::REG_HEIGHT:   restart = 1'b1;
        sharp3_pkg::REG_CHANNELS: restart = 1'b1;
        default:                  restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amount_q     <= sharp3_pkg::AMOUNT_RESET;
      image_width  <= sharp3_pkg::WIDTH_RESET;
      image_height <= sharp3_pkg::HEIGHT_RESET;
      channels     <= sharp3_pkg::CHANNELS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sharp3_pkg::REG_AMOUNT:   amount_q     <= cfg_data[sharp3_pkg::AMOUNT_W-1:0];
        sharp3_pkg::REG_WIDTH:    image_width  <= cfg_data[sharp3_pkg::WIDTH_REG_W-1:0];
        sharp3_pkg::REG_HEIGHT:   image_height <= cfg_data[sharp3_pkg::HEIGHT_REG_W-1:0];
        sharp3_pkg::REG_CHANNELS: channels     <= cfg_data[sharp3_pkg::CHAN_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (image_width == '0) begin
      w_eff = sharp3_pkg::WIDTH_REG_W'(1);
    end else if (image_width > sharp3_pkg::WIDTH_REG_W'(sharp3_pkg::MAX_WIDTH)) begin
      w_eff = sharp3_pkg::WIDTH_REG_W'(sharp3_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end

    if (image_height == '0) begin
      h_eff = sharp3_pkg::ROW_W'(1);
    end else if (image_height > sharp3_pkg::HEIGHT_REG_W'(sharp3_pkg::MAX_HEIGHT)) begin
      h_eff = sharp3_pkg::ROW_W'(sharp3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = sharp3_pkg::ROW_W'(image_height);
    end

    if (channels == '0) begin
      ch_eff = sharp3_pkg::CH_W'(1);
    end else if (channels > sharp3_pkg::CHAN_REG_W'(sharp3_pkg::MAX_CHANNELS)) begin
      ch_eff = sharp3_pkg::CH_W'(sharp3_pkg::MAX_CHANNELS);
    end else begin
      ch_eff = sharp3_pkg::CH_W'(channels);
    end

    wc = sharp3_pkg::WC_W'(w_eff) * sharp3_pkg::WC_W'(ch_eff);
  end

  // ---------------------------------------------------------------------------
  // stage 0: frame counters, line store access, border flags
  // ---------------------------------------------------------------------------
  logic [sharp3_pkg::COL_W-1:0]  col_count;
  logic [sharp3_pkg::ROW_W-1:0]  row_count;
  logic                          in_accept;
  logic                          draining;
  logic                          active;
  logic                          wrap;
  logic                          emit0;
  logic                          last0;
  logic                          last_col;
  logic [sharp3_pkg::COL_W-1:0]  ch_col;
  logic [sharp3_pkg::WC_W-1:0]   two_ch;
  logic [sharp3_pkg::ADDR_W-1:0] addr_cur;
  logic [sharp3_pkg::ADDR_W-1:0] addr_prev;
  logic                          store_we;
  stage1_t                       s1_next;

  logic [sharp3_pkg::SAMPLE_W-1:0] dsr [sharp3_pkg::MAX_CHANNELS];
  logic [sharp3_pkg::CH_W-1:0]     ch_m1;
  logic [CH2_W-1:0]                two_ch_m1;

  assign in_accept = in_valid && !in_stall;
  // draining once every row of the frame has arrived
  assign draining  = (row_count >= h_eff);
  assign active    = in_accept && ((operation == sharp3_pkg::OP_DRAIN) == draining);

  assign ch_col    = sharp3_pkg::COL_W'(ch_eff);
  assign two_ch    = sharp3_pkg::WC_W'({ch_eff, 1'b0});
  assign ch_m1     = ch_eff - sharp3_pkg::CH_W'(1);
  assign two_ch_m1 = {ch_eff, 1'b0} - CH2_W'(1);

  // center trails by one row and one pixel; in the first pixel of a row
  // the center lies at the end of the row before
  assign wrap     = (col_count < ch_col);
  assign emit0    = (row_count >= sharp3_pkg::ROW_W'(2)) ||
                    ((row_count == sharp3_pkg::ROW_W'(1)) && !wrap);
  assign last0    = (row_count == h_eff + sharp3_pkg::ROW_W'(1)) &&
                    (col_count == ch_col - sharp3_pkg::COL_W'(1));
  assign last_col = (sharp3_pkg::WC_W'(col_count) == wc - sharp3_pkg::WC_W'(1));

  // bank by row parity: current bank holds two rows back, the other one row back
  assign addr_cur  = {row_count[0], col_count};
  assign addr_prev = {~row_count[0], col_count};
  assign store_we  = active && (operation == sharp3_pkg::OP_SAMPLE);

  always_comb begin
    s1_next.emit     = emit0;
    s1_next.last     = last0;
    s1_next.right_ok = !wrap;
    if (wrap) begin
      s1_next.up_ok   = (row_count > sharp3_pkg::ROW_W'(2));
      s1_next.down_ok = (row_count <= h_eff);
      s1_next.left_ok = (SUM_W'(col_count) + SUM_W'(wc)) >= SUM_W'(two_ch);
    end else begin
      s1_next.up_ok   = (row_count > sharp3_pkg::ROW_W'(1));
      s1_next.down_ok = (row_count < h_eff);
      s1_next.left_ok = (sharp3_pkg::WC_W'(col_count) >= two_ch);
    end
    // pixel below the center is the sample one pixel back
    s1_next.down = dsr[sharp3_pkg::WIN_IDX_W'(ch_m1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (active) begin
      if (emit0 && last0) begin
        col_count <= '0;
        row_count <= '0;
      end else if (last_col) begin
        col_count <= '0;
        row_count <= row_count + sharp3_pkg::ROW_W'(1);
      end else begin
        col_count <= col_count + sharp3_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      dsr[0] <= sample;
      for (int i = 1; i < sharp3_pkg::MAX_CHANNELS; i++) begin
        dsr[i] <= dsr[i-1];
      end
    end
  end

  logic [sharp3_pkg::SAMPLE_W-1:0] rd_old;
  logic [sharp3_pkg::SAMPLE_W-1:0] rd_mid;

  sharp3_ram #(
    .WIDTH (sharp3_pkg::SAMPLE_W),
    .DEPTH (sharp3_pkg::STORE_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (addr_cur),
    .wdata   (sample),
    .raddr_a (addr_cur),
    .raddr_b (addr_prev),
    .rdata_a (rd_old),
    .rdata_b (rd_mid)
  );

  // ---------------------------------------------------------------------------
  // stage 1: neighbor windows on the ram outputs, laplacian difference
  // ---------------------------------------------------------------------------
  logic    p1_valid;
  stage1_t p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      p1 <= s1_next;
    end
  end

  logic [sharp3_pkg::SAMPLE_W-1:0] win [sharp3_pkg::MAX_CHANNELS];
  logic [sharp3_pkg::SAMPLE_W-1:0] msr [2 * sharp3_pkg::MAX_CHANNELS];
  logic [sharp3_pkg::SAMPLE_W-1:0] c1;
  logic [sharp3_pkg::SAMPLE_W-1:0] up_v;
  logic [sharp3_pkg::SAMPLE_W-1:0] down_v;
  logic [sharp3_pkg::SAMPLE_W-1:0] left_v;
  logic [sharp3_pkg::SAMPLE_W-1:0] right_v;
  logic [SUM4_W-1:0]               sum4;
  logic signed [DIFF_W-1:0]        diff1;

  always_comb begin
    c1      = msr[sharp3_pkg::MSR_IDX_W'(ch_m1)];
    up_v    = p1.up_ok    ? win[sharp3_pkg::WIN_IDX_W'(ch_m1)]     : c1;
    down_v  = p1.down_ok  ? p1.down                                : c1;
    left_v  = p1.left_ok  ? msr[sharp3_pkg::MSR_IDX_W'(two_ch_m1)] : c1;
    right_v = p1.right_ok ? rd_mid                                 : c1;
    sum4    = SUM4_W'(up_v) + SUM4_W'(down_v) + SUM4_W'(left_v) + SUM4_W'(right_v);
    diff1   = $signed(DIFF_W'({c1, 2'b00})) - $signed(DIFF_W'(sum4));
  end

  // win holds the row above, msr the center row, both one item per shift
  always_ff @(posedge clk) begin
    if (p1_valid) begin
      win[0] <= rd_old;
      for (int i = 1; i < sharp3_pkg::MAX_CHANNELS; i++) begin
        win[i] <= win[i-1];
      end
      msr[0] <= rd_mid;
      for (int i = 1; i < 2 * sharp3_pkg::MAX_CHANNELS; i++) begin
        msr[i] <= msr[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: scale by amount and add the center plus rounding bias
  // ---------------------------------------------------------------------------
  logic                            p2_valid;
  logic                            p2_last;
  logic [sharp3_pkg::SAMPLE_W-1:0] p2_c;
  logic signed [DIFF_W-1:0]        p2_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid && p1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid && p1.emit) begin
      p2_last <= p1.last;
      p2_c    <= c1;
      p2_diff <= diff1;
    end
  end

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_next;

  assign prod     = $signed({1'b0, amount_q}) * p2_diff;
  assign acc_next = ACC_W'(prod)
                  + $signed(ACC_W'({p2_c, {sharp3_pkg::AMOUNT_FRAC_BITS{1'b0}}}))
                  + ROUND_BIAS;

  // ---------------------------------------------------------------------------
  // stage 3: shift, clamp to 0..255, push into the result queue
  // ---------------------------------------------------------------------------
  logic                    p3_valid;
  logic                    p3_last;
  logic signed [ACC_W-1:0] p3_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_valid) begin
      p3_last <= p2_last;
      p3_acc  <= acc_next;
    end
  end

  logic [SHIFT_W-1:0]  shifted;
  sharp3_pkg::result_t push_item;

  assign shifted = p3_acc[ACC_W-1:sharp3_pkg::AMOUNT_FRAC_BITS];

  always_comb begin
    push_item.frame_end = p3_last;
    if (p3_acc[ACC_W-1]) begin
      push_item.value = '0;
    end else if (shifted[SHIFT_W-1:sharp3_pkg::SAMPLE_W] != '0) begin
      push_item.value = '1;
    end else begin
      push_item.value = shifted[sharp3_pkg::SAMPLE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // result queue and input credit
  // ---------------------------------------------------------------------------
  logic [sharp3_pkg::QUEUE_CNT_W-1:0] q_count;
  logic [1:0]                         inflight;
  logic [CREDIT_W-1:0]                credit_used;
  sharp3_pkg::result_t                q_head;

  sharp3_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (p3_valid),
    .push_item (push_item),
    .stall     (out_stall),
    .valid     (out_valid),
    .head      (q_head),
    .count     (q_count)
  );

  assign value     = q_head.value;
  assign frame_end = q_head.frame_end;

  // every emitting item in flight has a queue slot reserved
  assign inflight    = {1'b0, p1_valid && p1.emit} + {1'b0, p2_valid} + {1'b0, p3_valid};
  assign credit_used = CREDIT_W'(q_count) + CREDIT_W'(inflight);
  assign in_stall    = (credit_used >= CREDIT_W'(sharp3_pkg::QUEUE_DEPTH));

  `SH3_CHECK(a_credit_bound, credit_used <= CREDIT_W'(sharp3_pkg::QUEUE_DEPTH), "queue credit exceeded")
  `SH3_CHECK(a_col_in_row, sharp3_pkg::WC_W'(col_count) < wc, "column count past row length")
  `SH3_CHECK(a_row_in_frame, row_count <= h_eff + sharp3_pkg::ROW_W'(1), "row count past drain row")
  `SH3_CHECK_NEXT(a_frame_end_clears, active && emit0 && last0, (row_count == '0) && (col_count == '0), "counters not cleared after frame end")

endmodule

`default_nettype wire
